>>> sv/button_hold_motion_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button hold motion sequencer
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_HOLD_MOTION_SEQUENCER_ASSERT_SVH
`define BUTTON_HOLD_MOTION_SEQUENCER_ASSERT_SVH

// property that must hold at every edge
`define BHMS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BHMS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BHMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bhms_pkg.sv
// ----------------------------------------------------------------------------
// Button hold motion sequencer package
// Opcodes, button codes, register indexes, reset values, widths, queue depth
// and result type.
package bhms_pkg;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_START     = 3'd1,
		OP_STEER     = 3'd2,
		OP_SET_SPEED = 3'd3,
		OP_CANCEL    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		BTN_LEFT    = 3'd0,
		BTN_RIGHT   = 3'd1,
		BTN_UP      = 3'd2,
		BTN_DOWN    = 3'd3,
		BTN_RELEASE = 3'd4
	} button_t;

	typedef enum logic [2:0] {
		REG_RETRANSMIT = 3'd0,
		REG_SPEED_HOLD = 3'd1,
		REG_STEP_GAP   = 3'd2,
		REG_TOP_LEVEL  = 3'd3,
		REG_LEAST_MOVE = 3'd4
	} reg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned LEVEL_W    = 4;

	localparam logic [15:0] RETRANSMIT_RST = 16'd68;
	localparam logic [15:0] SPEED_HOLD_RST = 16'd1000;
	localparam logic [15:0] STEP_GAP_RST   = 16'd1000;
	localparam logic [3:0]  TOP_LEVEL_RST  = 4'd10;
	localparam logic [3:0]  LEAST_MOVE_RST = 4'd1;
	localparam logic [6:0]  CAP_TOP        = 7'd10;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 48;

	typedef struct packed {
		logic          button_valid;
		button_t       button_code;
		logic          last_of_run;
		logic [3:0]    speed_level_now;
		logic          navigating;
		logic          stopping;
		logic [31:0]   steered_ms_total;
	} res_t;

endpackage

>>> sv/button_hold_motion_sequencer.sv
// ----------------------------------------------------------------------------
// Button hold motion sequencer
// Times steering and speed button holds of a remote from 1 ms ticks.
// ----------------------------------------------------------------------------
// An input transfer is registered, then handled in one pass once the queue
// has room for two results, which updates all timers and levels and writes
// one or two results into a four-entry result queue. A new item is accepted
// every cycle while the queue has room for two results, and the queue drains
// one result per cycle while the receiver is ready, so items that give one
// result run at one per cycle and items that give two results only as fast
// as the queue drains. Configuration writes are always ready and take effect
// on the next item. tlast marks the final result of each input.
module button_hold_motion_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [0] steer_right, [16:1] steer_duration_ms, [23:17] speed_value
	input  logic [bhms_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [2:0] opcode
	input  logic [2:0]                      s_axis_tuser,
	// master side
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [2:0] button_code, [6:3] speed_level_now, [7] navigating, [8] stopping,
	// [40:9] steered_ms_total, [47:41] zero
	output logic [bhms_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] button_valid
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast,
	// configuration write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [2:0]                      cfg_index,
	input  logic [bhms_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bhms_pkg::*;

	`include "button_hold_motion_sequencer_assert.svh"

	// configuration
	logic [15:0] retx_q, hold_q, gap_q;
	logic [3:0]  top_q, least_q;

	// input stage
	logic        valid_s1;
	logic [2:0]  op_s1;
	logic        right_s1;
	logic [15:0] dur_s1;
	logic [6:0]  sv_s1;

	// sequencer state
	logic        steer_act_q, steer_right_q;
	logic [31:0] time_q, steer_start_q, steer_resend_q;
	logic [15:0] steer_len_q;
	logic        spd_act_q, spd_down_q;
	logic [31:0] spd_start_q, spd_resend_q, last_step_q;
	logic [3:0]  level_q, goal_q, cap_q;
	logic        nav_q, stop_q;
	logic [31:0] total_q;

	// next state
	logic        steer_act_d, steer_right_d;
	logic [31:0] time_d, steer_start_d, steer_resend_d;
	logic [15:0] steer_len_d;
	logic        spd_act_d, spd_down_d;
	logic [31:0] spd_start_d, spd_resend_d, last_step_d;
	logic [3:0]  level_d, goal_d, cap_d;
	logic        nav_d, stop_d;
	logic [31:0] total_d;
	button_t     pkt0, pkt1;
	logic [1:0]  npkt;

	// result queue
	res_t             fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic             fire, pop;
	res_t             res0, res1;

	assign fire          = valid_s1 && (cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || fire;
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retx_q  <= RETRANSMIT_RST;
			hold_q  <= SPEED_HOLD_RST;
			gap_q   <= STEP_GAP_RST;
			top_q   <= TOP_LEVEL_RST;
			least_q <= LEAST_MOVE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_RETRANSMIT: retx_q  <= cfg_data;
				REG_SPEED_HOLD: hold_q  <= cfg_data;
				REG_STEP_GAP:   gap_q   <= cfg_data;
				REG_TOP_LEVEL:  top_q   <= cfg_data[3:0];
				REG_LEAST_MOVE: least_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1    <= s_axis_tuser;
			right_s1 <= s_axis_tdata[0];
			dur_s1   <= s_axis_tdata[16:1];
			sv_s1    <= s_axis_tdata[23:17];
		end
	end

	always_comb begin
		logic        clr;
		logic        set_nav;
		logic        speed_run;
		logic [31:0] t_n;
		logic [4:0]  up;
		logic [6:0]  g;
		logic [32:0] sum;
		logic [32:0] delta;

		clr     = 1'b0;
		set_nav = 1'b0;
		npkt    = 2'd0;
		pkt0    = BTN_LEFT;
		pkt1    = BTN_LEFT;
		t_n     = time_q + 32'd1;
		up      = {1'b0, level_q} + 5'd1;
		g       = '0;
		sum     = '0;
		delta   = '0;
		speed_run = 1'b0;

		time_d         = time_q;
		steer_act_d    = steer_act_q;
		steer_right_d  = steer_right_q;
		steer_start_d  = steer_start_q;
		steer_resend_d = steer_resend_q;
		steer_len_d    = steer_len_q;
		spd_act_d      = spd_act_q;
		spd_down_d     = spd_down_q;
		spd_start_d    = spd_start_q;
		spd_resend_d   = spd_resend_q;
		last_step_d    = last_step_q;
		level_d        = level_q;
		goal_d         = goal_q;
		cap_d          = cap_q;
		nav_d          = nav_q;
		stop_d         = stop_q;
		total_d        = total_q;

		unique case (op_t'(op_s1))
			OP_TICK: begin
				time_d = t_n;
				if (stop_q) begin
					speed_run = 1'b1;
				end else if (nav_q) begin
					// steering hold first
					if (steer_act_q) begin
						if ((t_n - steer_start_q) >= {16'h0, steer_len_q}) begin
							pkt0        = BTN_RELEASE;
							npkt        = 2'd1;
							steer_act_d = 1'b0;
						end else if ((t_n - steer_resend_q) >= {16'h0, retx_q}) begin
							pkt0           = steer_right_q ? BTN_RIGHT : BTN_LEFT;
							npkt           = 2'd1;
							steer_resend_d = t_n;
						end
					end
					// speed stepper waits out an active steering hold
					speed_run = !steer_act_d;
				end
				if (speed_run) begin
					if (spd_act_q) begin
						if ((t_n - spd_start_q) >= {16'h0, hold_q}) begin
							if (npkt == 2'd0) pkt0 = BTN_RELEASE;
							else pkt1 = BTN_RELEASE;
							npkt      = npkt + 2'd1;
							spd_act_d = 1'b0;
							if (spd_down_q) begin
								level_d = (level_q != 4'd0) ? level_q - 4'd1 : 4'd0;
							end else begin
								level_d = (up < {1'b0, top_q}) ? up[3:0] : top_q;
							end
							last_step_d = t_n;
						end else if ((t_n - spd_resend_q) >= {16'h0, retx_q}) begin
							if (npkt == 2'd0) pkt0 = spd_down_q ? BTN_DOWN : BTN_UP;
							else pkt1 = spd_down_q ? BTN_DOWN : BTN_UP;
							npkt         = npkt + 2'd1;
							spd_resend_d = t_n;
						end
					end else if (level_q != goal_q
						&& (t_n - last_step_q) >= {16'h0, gap_q}) begin
						if (npkt == 2'd0) pkt0 = (goal_q < level_q) ? BTN_DOWN : BTN_UP;
						else pkt1 = (goal_q < level_q) ? BTN_DOWN : BTN_UP;
						npkt         = npkt + 2'd1;
						spd_act_d    = 1'b1;
						spd_down_d   = goal_q < level_q;
						spd_start_d  = t_n;
						spd_resend_d = t_n;
					end
				end
				// stopping finishes once everything has wound down
				if (stop_q && level_d == 4'd0 && !spd_act_d && goal_q == 4'd0) begin
					clr = 1'b1;
				end
			end
			OP_START: begin
				clr     = 1'b1;
				set_nav = 1'b1;
				if (sv_s1 == 7'd0)       cap_d = 4'd1;
				else if (sv_s1 > CAP_TOP) cap_d = CAP_TOP[3:0];
				else                      cap_d = sv_s1[3:0];
			end
			OP_STEER: begin
				if (nav_q) begin
					pkt0           = right_s1 ? BTN_RIGHT : BTN_LEFT;
					npkt           = 2'd1;
					steer_act_d    = 1'b1;
					steer_right_d  = right_s1;
					steer_start_d  = time_q;
					steer_resend_d = time_q;
					steer_len_d    = dur_s1;
					delta = right_s1 ? {17'h0, dur_s1} : -{17'h0, dur_s1};
					sum   = {total_q[31], total_q} + delta;
					// saturate to the signed 32-bit range
					if (!sum[32] && sum[31])      total_d = 32'h7fff_ffff;
					else if (sum[32] && !sum[31]) total_d = 32'h8000_0000;
					else                          total_d = sum[31:0];
				end
			end
			OP_SET_SPEED: begin
				if (nav_q && !stop_q) begin
					g = (sv_s1 < {3'h0, cap_q}) ? sv_s1 : {3'h0, cap_q};
					if (g != 7'd0 && g < {3'h0, least_q}) g = {3'h0, least_q};
					goal_d = g[3:0];
				end
			end
			OP_CANCEL: begin
				if (nav_q || stop_q) begin
					if (steer_act_q) begin
						pkt0        = BTN_RELEASE;
						npkt        = 2'd1;
						steer_act_d = 1'b0;
					end
					nav_d = 1'b0;
					if (level_q != 4'd0 || spd_act_q) begin
						if (npkt == 2'd0) pkt0 = BTN_DOWN;
						else pkt1 = BTN_DOWN;
						npkt         = npkt + 2'd1;
						spd_act_d    = 1'b1;
						spd_down_d   = 1'b1;
						spd_start_d  = time_q;
						spd_resend_d = time_q;
						goal_d       = 4'd0;
						stop_d       = 1'b1;
					end else begin
						clr = 1'b1;
					end
				end
			end
			default: ;
		endcase

		if (clr) begin
			steer_act_d    = 1'b0;
			steer_right_d  = 1'b0;
			steer_start_d  = '0;
			steer_resend_d = '0;
			steer_len_d    = '0;
			spd_act_d      = 1'b0;
			spd_down_d     = 1'b0;
			spd_start_d    = '0;
			spd_resend_d   = '0;
			last_step_d    = '0;
			level_d        = '0;
			goal_d         = '0;
			total_d        = '0;
			nav_d          = 1'b0;
			stop_d         = 1'b0;
		end
		if (set_nav) begin
			nav_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q         <= '0;
			steer_act_q    <= 1'b0;
			steer_right_q  <= 1'b0;
			steer_start_q  <= '0;
			steer_resend_q <= '0;
			steer_len_q    <= '0;
			spd_act_q      <= 1'b0;
			spd_down_q     <= 1'b0;
			spd_start_q    <= '0;
			spd_resend_q   <= '0;
			last_step_q    <= '0;
			level_q        <= '0;
			goal_q         <= '0;
			cap_q          <= '0;
			nav_q          <= 1'b0;
			stop_q         <= 1'b0;
			total_q        <= '0;
		end else if (fire) begin
			time_q         <= time_d;
			steer_act_q    <= steer_act_d;
			steer_right_q  <= steer_right_d;
			steer_start_q  <= steer_start_d;
			steer_resend_q <= steer_resend_d;
			steer_len_q    <= steer_len_d;
			spd_act_q      <= spd_act_d;
			spd_down_q     <= spd_down_d;
			spd_start_q    <= spd_start_d;
			spd_resend_q   <= spd_resend_d;
			last_step_q    <= last_step_d;
			level_q        <= level_d;
			goal_q         <= goal_d;
			cap_q          <= cap_d;
			nav_q          <= nav_d;
			stop_q         <= stop_d;
			total_q        <= total_d;
		end
	end

	// results carry the state after the whole input
	always_comb begin
		res0.button_valid     = npkt != 2'd0;
		res0.button_code      = (npkt != 2'd0) ? pkt0 : BTN_LEFT;
		res0.last_of_run      = npkt != 2'd2;
		res0.speed_level_now  = level_d;
		res0.navigating       = nav_d;
		res0.stopping         = stop_d;
		res0.steered_ms_total = total_d;
		res1                  = res0;
		res1.button_code      = pkt1;
		res1.last_of_run      = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			fifo_q[wr_ptr_q] <= res0;
			if (npkt == 2'd2) begin
				fifo_q[wr_ptr_q + FIFO_AW'(1)] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + ((npkt == 2'd2) ? FIFO_AW'(2) : FIFO_AW'(1));
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q
				+ (fire ? ((npkt == 2'd2) ? (FIFO_AW+1)'(2) : (FIFO_AW+1)'(1))
					: (FIFO_AW+1)'(0))
				- (pop ? (FIFO_AW+1)'(1) : (FIFO_AW+1)'(0));
		end
	end

	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tuser  = fifo_q[rd_ptr_q].button_valid;
	assign m_axis_tlast  = fifo_q[rd_ptr_q].last_of_run;
	assign m_axis_tdata  = {7'h0,
		fifo_q[rd_ptr_q].steered_ms_total,
		fifo_q[rd_ptr_q].stopping,
		fifo_q[rd_ptr_q].navigating,
		fifo_q[rd_ptr_q].speed_level_now,
		fifo_q[rd_ptr_q].button_code};

	`BHMS_ASSERT_ALWAYS(a_fifo_bound, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")
	`BHMS_ASSERT_ALWAYS(a_mode_excl, !(nav_q && stop_q), "navigating and stopping both set")
	`BHMS_ASSERT_IMPL(a_stop_no_steer, stop_q, !steer_act_q, "steering hold active while stopping")
	`BHMS_ASSERT_NEXT(a_fire_result, fire, m_axis_tvalid, "handled item left no result")

endmodule
